@@ hw/rtl/mme_pkg.sv @@
// Shared types, constants and helpers for the matrix multiply engine.
`timescale 1ns / 1ps

package mme_pkg;

   localparam int DEF_MAX_DIM = 8;
   localparam int DIM_W       = 4;
   localparam int ELEM_W      = 16;
   localparam int PROD_W      = 2 * ELEM_W;
   localparam int OUT_W       = 35;
   localparam int IDX_W       = 3;
   localparam int CSR_IDX_W   = 2;

   localparam logic signed [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
   localparam logic signed [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

   typedef enum logic [1:0] {
      REQ_LOAD_A = 2'd0,
      REQ_LOAD_B = 2'd1,
      REQ_ROW    = 2'd2,
      REQ_NONE   = 2'd3
   } req_code_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ROWS_M  = 2'd0,
      CSR_COLS_N  = 2'd1,
      CSR_DEPTH_K = 2'd2,
      CSR_SPARE   = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MAC,
      ST_FLUSH,
      ST_DRAIN
   } state_type;

   function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                  input int max_dim);
      logic [DIM_W-1:0] r;
      r = v;
      if (v == '0) begin
         r = DIM_W'(1);
      end else if (int'(v) > max_dim) begin
         r = DIM_W'(max_dim);
      end
      return r;
   endfunction

endpackage

@@ hw/rtl/matrix_multiply_engine_top.sv @@
// Top level of the matrix multiply engine: stores, multiply pipeline and cell ring.
`timescale 1ns / 1ps

// A load word writes one element of A or B. For a row request, one shared
// 16x16 multiplier fed by one read port on each store walks the n*k products,
// each added into a ring of accumulator cells that rotates one place per
// product, so that after the walk the ring holds the n results; these then
// leave one per cycle, unless rsp_stall holds the output register, from the
// ring tail through that register. The stores need no clearing after reset.
module matrix_multiply_engine_top #(
   parameter int MAX_DIM = mme_pkg::DEF_MAX_DIM
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [1:0]                           req_type,
   input  logic [mme_pkg::IDX_W-1:0]            req_row_index,
   input  logic [mme_pkg::IDX_W-1:0]            req_col_index,
   input  logic signed [mme_pkg::ELEM_W-1:0]    req_elem_value,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [mme_pkg::IDX_W-1:0]            rsp_out_row,
   output logic [mme_pkg::IDX_W-1:0]            rsp_out_col,
   output logic signed [mme_pkg::OUT_W-1:0]     rsp_out_value,
   output logic                                 rsp_last,
   input  logic                                 csr_wr_en,
   input  logic [mme_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [mme_pkg::DIM_W-1:0]            csr_wr_data
);

   import mme_pkg::*;

   localparam int DEPTH  = MAX_DIM * MAX_DIM;
   localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW     = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
   localparam int ACC_W  = PROD_W + $clog2(MAX_DIM);

   logic [DIM_W-1:0] rows_m_ff, cols_n_ff, depth_k_ff;
   logic [DIM_W-1:0] m_eff, n_eff, k_eff;

   state_type state_ff, state_in;
   logic [DIM_W-1:0] t_cnt_ff, t_cnt_in;
   logic [DIM_W-1:0] j_cnt_ff, j_cnt_in;
   logic [IDX_W-1:0] row_ff, row_in;

   logic s1_valid_ff, s1_first_ff, s2_valid_ff, s2_first_ff;
   logic signed [PROD_W-1:0] prod_ff;

   logic req_accept, issue, drain_take;
   logic a_wr, b_wr;
   logic [AW-1:0] wr_addr, a_rd_addr, b_rd_addr;
   logic signed [ELEM_W-1:0] a_rd, b_rd;

   logic ring_shift;
   logic signed [ACC_W-1:0] ring_q [MAX_DIM];
   logic signed [ACC_W-1:0] ring_head, ring_tail;
   logic [CW-1:0] tail_idx;
   logic signed [OUT_W-1:0] tail_sat;

   logic rsp_valid_ff;
   logic [IDX_W-1:0] rsp_row_ff, rsp_col_ff;
   logic signed [OUT_W-1:0] rsp_value_ff;
   logic rsp_last_ff;

   assign m_eff = clamp_dim(rows_m_ff, MAX_DIM);
   assign n_eff = clamp_dim(cols_n_ff, MAX_DIM);
   assign k_eff = clamp_dim(depth_k_ff, MAX_DIM);

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_m_ff  <= DIM_W'(8);
         cols_n_ff  <= DIM_W'(8);
         depth_k_ff <= DIM_W'(8);
      end else if (csr_wr_en) begin
         case (csr_index_type'(csr_index))
            CSR_ROWS_M:  rows_m_ff  <= csr_wr_data;
            CSR_COLS_N:  cols_n_ff  <= csr_wr_data;
            CSR_DEPTH_K: depth_k_ff <= csr_wr_data;
            default: ;
         endcase
      end
   end

   assign req_accept = req_valid && !req_stall;
   assign a_wr = req_accept && (req_type == REQ_LOAD_A) &&
                 ({1'b0, req_row_index} < m_eff) && ({1'b0, req_col_index} < k_eff);
   assign b_wr = req_accept && (req_type == REQ_LOAD_B) &&
                 ({1'b0, req_row_index} < k_eff) && ({1'b0, req_col_index} < n_eff);
   assign wr_addr   = AW'(32'(req_row_index) * MAX_DIM + 32'(req_col_index));
   assign a_rd_addr = AW'(32'(row_ff) * MAX_DIM + 32'(t_cnt_ff));
   assign b_rd_addr = AW'(32'(t_cnt_ff) * MAX_DIM + 32'(j_cnt_ff));

   mme_ram #(.WIDTH(ELEM_W), .DEPTH(DEPTH), .ADDR_W(AW)) u_a_store (
      .clock   (clock),
      .wr_en   (a_wr),
      .wr_addr (wr_addr),
      .wr_data (req_elem_value),
      .rd_en   (issue),
      .rd_addr (a_rd_addr),
      .rd_data (a_rd)
   );

   mme_ram #(.WIDTH(ELEM_W), .DEPTH(DEPTH), .ADDR_W(AW)) u_b_store (
      .clock   (clock),
      .wr_en   (b_wr),
      .wr_addr (wr_addr),
      .wr_data (req_elem_value),
      .rd_en   (issue),
      .rd_addr (b_rd_addr),
      .rd_data (b_rd)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         s1_valid_ff <= issue;
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      t_cnt_ff    <= t_cnt_in;
      j_cnt_ff    <= j_cnt_in;
      row_ff      <= row_in;
      s1_first_ff <= (t_cnt_ff == '0);
      s2_first_ff <= s1_first_ff;
      if (s1_valid_ff) begin
         prod_ff <= a_rd * b_rd;
      end
   end

   always_comb begin
      state_in   = state_ff;
      t_cnt_in   = t_cnt_ff;
      j_cnt_in   = j_cnt_ff;
      row_in     = row_ff;
      req_stall  = 1'b1;
      issue      = 1'b0;
      drain_take = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            t_cnt_in  = '0;
            j_cnt_in  = '0;
            if (req_accept && (req_type == REQ_ROW) && ({1'b0, req_row_index} < m_eff)) begin
               row_in   = req_row_index;
               state_in = ST_MAC;
            end
         end
         ST_MAC: begin
            issue = 1'b1;
            if (j_cnt_ff == n_eff - 1'b1) begin
               j_cnt_in = '0;
               if (t_cnt_ff == k_eff - 1'b1) begin
                  state_in = ST_FLUSH;
               end else begin
                  t_cnt_in = t_cnt_ff + 1'b1;
               end
            end else begin
               j_cnt_in = j_cnt_ff + 1'b1;
            end
         end
         ST_FLUSH: begin
            if (!s1_valid_ff && !s2_valid_ff) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               drain_take = 1'b1;
               j_cnt_in   = j_cnt_ff + 1'b1;
               if (j_cnt_ff == n_eff - 1'b1) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign tail_idx   = CW'(n_eff - 1'b1);
   assign ring_tail  = ring_q[tail_idx];
   assign ring_shift = s2_valid_ff || drain_take;
   assign ring_head  = drain_take ? ring_tail
                                  : (s2_first_ff ? '0 : ring_tail) + ACC_W'(prod_ff);

   for (genvar i = 0; i < MAX_DIM; i++) begin : g_ring
      logic signed [ACC_W-1:0] cell_in;
      if (i == 0) begin : g_head
         assign cell_in = ring_head;
      end else begin : g_link
         assign cell_in = ring_q[i-1];
      end
      mme_cell #(.ACC_W(ACC_W)) u_cell (
         .clock    (clock),
         .shift_en (ring_shift),
         .acc_in   (cell_in),
         .acc_out  (ring_q[i])
      );
   end

   if (ACC_W > OUT_W) begin : g_sat
      assign tail_sat = (ring_tail > ACC_W'(OUT_MAX)) ? OUT_MAX :
                        (ring_tail < ACC_W'(OUT_MIN)) ? OUT_MIN : ring_tail[OUT_W-1:0];
   end else begin : g_ext
      assign tail_sat = OUT_W'(ring_tail);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (drain_take) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (drain_take) begin
         rsp_row_ff   <= row_ff;
         rsp_col_ff   <= j_cnt_ff[IDX_W-1:0];
         rsp_value_ff <= tail_sat;
         rsp_last_ff  <= (j_cnt_ff == n_eff - 1'b1);
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_row   = rsp_row_ff;
   assign rsp_out_col   = rsp_col_ff;
   assign rsp_out_value = rsp_value_ff;
   assign rsp_last      = rsp_last_ff;

   a_drain_pipe_empty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DRAIN) |-> (!s1_valid_ff && !s2_valid_ff))
      else $error("product still in flight during drain");

   a_prod_in_walk: assert property (@(posedge clock) disable iff (reset)
      s2_valid_ff |-> (state_ff == ST_MAC || state_ff == ST_FLUSH))
      else $error("product outside the multiply walk");

   a_mac_bounds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MAC) |-> (t_cnt_ff < k_eff && j_cnt_ff < n_eff))
      else $error("walk counter out of range");

   a_mid_row_in_drain: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_last_ff) |-> (state_ff == ST_DRAIN))
      else $error("non-final word pending outside drain");

   a_issue_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MAC && state_in == ST_FLUSH) |=> s1_valid_ff)
      else $error("final product lost at end of walk");

endmodule

@@ hw/rtl/mme_ram.sv @@
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps

module mme_ram #(
   parameter int WIDTH  = 16,
   parameter int DEPTH  = 64,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hw/rtl/mme_cell.sv @@
// One accumulator cell of the rotating column ring.
`timescale 1ns / 1ps

module mme_cell #(
   parameter int ACC_W = 35
) (
   input  logic                    clock,
   input  logic                    shift_en,
   input  logic signed [ACC_W-1:0] acc_in,
   output logic signed [ACC_W-1:0] acc_out
);

   logic signed [ACC_W-1:0] acc_ff;

   always_ff @(posedge clock) begin
      if (shift_en) begin
         acc_ff <= acc_in;
      end
   end

   assign acc_out = acc_ff;

endmodule

@@ tb/sv/tb_top.sv @@
// Self-checking bench for the matrix multiply engine: store loads, row requests, size registers.
`timescale 1ns / 1ps

module tb_top;
   import mme_pkg::*;

   localparam int DIM         = DEF_MAX_DIM;
   localparam int SETTLE      = 100;
   localparam int QUIET_LIMIT = 4000;

   typedef struct packed {
      req_code_type      kind;
      logic [IDX_W-1:0]  row;
      logic [IDX_W-1:0]  col;
      logic [ELEM_W-1:0] value;
   } mme_word_type;

   typedef struct packed {
      logic [IDX_W-1:0] row;
      logic [IDX_W-1:0] col;
      logic [OUT_W-1:0] value;
      logic             last;
   } dot_type;

   logic                      clock          = 1'b0;
   logic                      reset          = 1'b1;
   logic                      req_valid      = 1'b0;
   logic                      req_stall;
   logic [1:0]                req_type       = '0;
   logic [IDX_W-1:0]          req_row_index  = '0;
   logic [IDX_W-1:0]          req_col_index  = '0;
   logic signed [ELEM_W-1:0]  req_elem_value = '0;
   logic                      rsp_valid;
   logic                      rsp_stall      = 1'b0;
   logic [IDX_W-1:0]          rsp_out_row;
   logic [IDX_W-1:0]          rsp_out_col;
   logic signed [OUT_W-1:0]   rsp_out_value;
   logic                      rsp_last;
   logic                      csr_wr_en      = 1'b0;
   csr_index_type             csr_index      = CSR_ROWS_M;
   logic [DIM_W-1:0]          csr_wr_data    = '0;

   logic [ELEM_W-1:0] a_elems [DIM*DIM];
   logic [ELEM_W-1:0] b_elems [DIM*DIM];
   logic [DIM_W-1:0]  dim_rows  = DIM_W'(DIM);
   logic [DIM_W-1:0]  dim_cols  = DIM_W'(DIM);
   logic [DIM_W-1:0]  dim_depth = DIM_W'(DIM);

   mme_word_type word_q[$];
   dot_type      dot_q[$];
   mme_word_type next_word;
   mme_word_type taken_word;
   dot_type      got_dot;
   dot_type      want_dot;
   logic         req_taken     = 1'b0;
   int           send_idle_pct = 0;
   int           stall_pct     = 0;
   int           mismatches    = 0;
   int           quiet_cycles  = 0;

   matrix_multiply_engine_top u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_type       (req_type),
      .req_row_index  (req_row_index),
      .req_col_index  (req_col_index),
      .req_elem_value (req_elem_value),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_row    (rsp_out_row),
      .rsp_out_col    (rsp_out_col),
      .rsp_out_value  (rsp_out_value),
      .rsp_last       (rsp_last),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wr_data    (csr_wr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic int span(input logic [DIM_W-1:0] v);
      if (v == '0) begin
         return 1;
      end
      if (int'(v) > DIM) begin
         return DIM;
      end
      return int'(v);
   endfunction

   task automatic absorb_word(input mme_word_type w);
      int      m;
      int      n;
      int      k;
      longint  acc;
      dot_type d;
      m = span(dim_rows);
      n = span(dim_cols);
      k = span(dim_depth);
      case (w.kind)
         REQ_LOAD_A: begin
            if (int'(w.row) < m && int'(w.col) < k) begin
               a_elems[int'(w.row) * DIM + int'(w.col)] = w.value;
            end
         end
         REQ_LOAD_B: begin
            if (int'(w.row) < k && int'(w.col) < n) begin
               b_elems[int'(w.row) * DIM + int'(w.col)] = w.value;
            end
         end
         REQ_ROW: begin
            if (int'(w.row) < m) begin
               for (int j = 0; j < n; j++) begin
                  acc = 0;
                  for (int t = 0; t < k; t++) begin
                     acc += longint'($signed(a_elems[int'(w.row) * DIM + t]))
                          * longint'($signed(b_elems[t * DIM + j]));
                  end
                  if (acc > longint'(OUT_MAX)) begin
                     acc = longint'(OUT_MAX);
                  end
                  if (acc < longint'(OUT_MIN)) begin
                     acc = longint'(OUT_MIN);
                  end
                  d.row   = w.row;
                  d.col   = IDX_W'(j);
                  d.value = OUT_W'(acc);
                  d.last  = (j == n - 1);
                  dot_q.push_back(d);
               end
            end
         end
         default: begin
         end
      endcase
   endtask

   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (word_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            next_word = word_q.pop_front();
            req_valid      <= 1'b1;
            req_type       <= next_word.kind;
            req_row_index  <= next_word.row;
            req_col_index  <= next_word.col;
            req_elem_value <= next_word.value;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   always @(posedge clock) begin
      req_taken <= req_valid && !req_stall;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_ROWS_M:  dim_rows  <= csr_wr_data;
            CSR_COLS_N:  dim_cols  <= csr_wr_data;
            CSR_DEPTH_K: dim_depth <= csr_wr_data;
            default: begin
            end
         endcase
      end
      if (req_valid && !req_stall) begin
         taken_word = {req_code_type'(req_type), req_row_index, req_col_index, req_elem_value};
         absorb_word(taken_word);
      end
      if (rsp_valid && !rsp_stall) begin
         got_dot = {rsp_out_row, rsp_out_col, rsp_out_value, rsp_last};
         if (dot_q.size() == 0) begin
            if (mismatches < 10) begin
               $display("unexpected result: row %0d col %0d value %0d last %0b",
                        got_dot.row, got_dot.col, $signed(got_dot.value), got_dot.last);
            end
            mismatches++;
         end else begin
            want_dot = dot_q.pop_front();
            if (got_dot !== want_dot) begin
               if (mismatches < 10) begin
                  $display("mismatch: expected row %0d col %0d value %0d last %0b",
                           want_dot.row, want_dot.col, $signed(want_dot.value),
                           want_dot.last);
                  $display("          got      row %0d col %0d value %0d last %0b",
                           got_dot.row, got_dot.col, $signed(got_dot.value), got_dot.last);
               end
               mismatches++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_wr_en) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("tb_top: errors");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic logic [ELEM_W-1:0] rand_elem();
      case ($urandom_range(9))
         0:       return 16'h8000;
         1:       return 16'h7FFF;
         2:       return 16'h0000;
         3:       return 16'hFFFF;
         default: return ELEM_W'($urandom);
      endcase
   endfunction

   task automatic send(input req_code_type kind, input logic [IDX_W-1:0] row,
                       input logic [IDX_W-1:0] col, input logic [ELEM_W-1:0] value);
      mme_word_type w;
      w.kind  = kind;
      w.row   = row;
      w.col   = col;
      w.value = value;
      word_q.push_back(w);
   endtask

   task automatic drain();
      while (word_q.size() != 0 || req_valid || dot_q.size() != 0) begin
         @(posedge clock);
      end
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [DIM_W-1:0] v);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= v;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   task automatic set_dims(input logic [DIM_W-1:0] m, input logic [DIM_W-1:0] n,
                           input logic [DIM_W-1:0] k);
      drain();
      repeat (SETTLE) @(posedge clock);
      write_reg(CSR_ROWS_M, m);
      write_reg(CSR_COLS_N, n);
      write_reg(CSR_DEPTH_K, k);
      @(posedge clock);
   endtask

   task automatic run_random(input int useful, input int hold_at);
      int m;
      int n;
      int k;
      int done;
      int pick;
      m = span(dim_rows);
      n = span(dim_cols);
      k = span(dim_depth);
      done = 0;
      while (done < useful) begin
         if (done == hold_at) begin
            drain();
            hold_at = -1;
         end
         pick = $urandom_range(99);
         if (pick < 38) begin
            send(REQ_LOAD_A, IDX_W'($urandom_range(m - 1)), IDX_W'($urandom_range(k - 1)),
                 rand_elem());
            done++;
         end else if (pick < 70) begin
            send(REQ_LOAD_B, IDX_W'($urandom_range(k - 1)), IDX_W'($urandom_range(n - 1)),
                 rand_elem());
            done++;
         end else if (pick < 88) begin
            send(REQ_ROW, IDX_W'($urandom_range(m - 1)), IDX_W'($urandom), ELEM_W'($urandom));
            done++;
         end else begin
            send(req_code_type'($urandom_range(3)), IDX_W'($urandom), IDX_W'($urandom),
                 ELEM_W'($urandom));
         end
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int r = 0; r < DIM; r++) begin
         for (int c = 0; c < DIM; c++) begin
            send(REQ_LOAD_A, IDX_W'(r), IDX_W'(c),
                 (r == 0) ? 16'h8000 : (r == DIM - 1) ? 16'h7FFF : rand_elem());
            send(REQ_LOAD_B, IDX_W'(r), IDX_W'(c),
                 (c == 0) ? 16'h8000 : (c == DIM - 1) ? 16'h7FFF : rand_elem());
         end
      end
      send(REQ_ROW, 3'd0, 3'd7, 16'hFFFF);
      send(REQ_ROW, 3'd7, 3'd0, 16'h0000);
      send(REQ_NONE, 3'd7, 3'd7, 16'hFFFF);
      send(REQ_ROW, 3'd3, 3'd5, 16'h5555);

      set_dims(4'd1, 4'd1, 4'd1);
      send(REQ_LOAD_A, 3'd1, 3'd0, 16'h1234);
      send(REQ_LOAD_A, 3'd0, 3'd1, 16'h1234);
      send(REQ_LOAD_B, 3'd1, 3'd0, 16'h4321);
      send(REQ_LOAD_B, 3'd0, 3'd1, 16'h4321);
      send(REQ_ROW, 3'd1, 3'd0, 16'h0000);
      send(REQ_LOAD_A, 3'd0, 3'd0, 16'h7FFF);
      send(REQ_LOAD_B, 3'd0, 3'd0, 16'h8000);
      send(REQ_ROW, 3'd0, 3'd3, 16'h0000);

      set_dims(4'd0, 4'd0, 4'd0);
      send(REQ_ROW, 3'd0, 3'd0, 16'h0000);
      send(REQ_ROW, 3'd1, 3'd0, 16'h0000);

      set_dims(4'd15, 4'd15, 4'd15);
      send(REQ_ROW, 3'd7, 3'd7, 16'h0000);
      send(REQ_ROW, 3'd0, 3'd0, 16'h0000);

      for (int p = 0; p < 8; p++) begin
         if (p == 0) begin
            set_dims(4'd8, 4'd8, 4'd8);
         end else begin
            set_dims(DIM_W'($urandom_range(15)), DIM_W'($urandom_range(15)),
                     DIM_W'($urandom_range(15)));
         end
         case (p % 4)
            0: begin
               send_idle_pct = 0;
               stall_pct     = 0;
            end
            1: begin
               send_idle_pct = 67;
               stall_pct     = 0;
            end
            2: begin
               send_idle_pct = 0;
               stall_pct     = 67;
            end
            default: begin
               send_idle_pct = 25;
               stall_pct     = 25;
            end
         endcase
         run_random(32, (p == 2) ? 16 : -1);
      end
      drain();
      write_reg(CSR_SPARE, 4'd5);

      drain();
      repeat (SETTLE) @(posedge clock);
      if (mismatches == 0) begin
         $display("tb_top: clean");
      end else begin
         $display("tb_top: errors");
      end
      $finish;
   end

endmodule
